/* rtl/sha1_pkg.sv */
// Shared types, constants and helper functions for the SHA-1 digest block.
// Used by sha1_sched, sha1_round and sha1_message_digest_top; no dependencies.
package sha1_pkg;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int NUM_H    = 5;
    localparam int SCHED_N  = 16;
    localparam int ROUNDS   = 80;
    localparam int RND_W    = 7;
    localparam int PEND_W   = 6;
    localparam int LEN_W    = 64;
    localparam int BLK_W    = LEN_W - PEND_W - 3;
    localparam int IDX_W    = 3;
    localparam int LEN_START = 56;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [RND_W-1:0]  rnd_t;

    localparam byte_t PAD_MARK = 8'h80;

    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    localparam word_t H_INIT [0:NUM_H-1] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Controls for the message schedule shift register.
    typedef struct packed {
        logic  shift_byte;
        byte_t byte_val;
        logic  step;
    } sched_ctl_t;

    // Controls for the round datapath and the chaining words.
    typedef struct packed {
        logic load_iv;
        logic init;
        logic step;
        logic add;
        rnd_t rnd;
    } round_ctl_t;

    function automatic word_t round_f(rnd_t rnd, word_t b, word_t c, word_t d);
        word_t f;
        if (rnd < RND_W'(20)) begin
            f = (b & c) | (~b & d);
        end else if (rnd < RND_W'(40)) begin
            f = b ^ c ^ d;
        end else if (rnd < RND_W'(60)) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic word_t round_k(rnd_t rnd);
        word_t k;
        if (rnd < RND_W'(20)) begin
            k = K_0;
        end else if (rnd < RND_W'(40)) begin
            k = K_1;
        end else if (rnd < RND_W'(60)) begin
            k = K_2;
        end else begin
            k = K_3;
        end
        return k;
    endfunction

endpackage

/* rtl/sha1_sched.sv */
// Message block store and SHA-1 message schedule as one 16-word shift register.
// Depends on sha1_pkg for widths and the control struct.
module sha1_sched (
    input  logic                 clk,
    input  sha1_pkg::sched_ctl_t ctl,
    output sha1_pkg::word_t      m
);

    localparam int VEC_W = sha1_pkg::SCHED_N * sha1_pkg::WORD_W;
    localparam int W_W   = sha1_pkg::WORD_W;

    // Word j of the window sits at the top minus j words; word 0 is W[r].
    logic [VEC_W-1:0] q_reg;
    sha1_pkg::word_t  w0, w2, w8, w13, x, w_new;

    assign w0  = q_reg[VEC_W-1           -: W_W];
    assign w2  = q_reg[VEC_W-1 - 2*W_W   -: W_W];
    assign w8  = q_reg[VEC_W-1 - 8*W_W   -: W_W];
    assign w13 = q_reg[VEC_W-1 - 13*W_W  -: W_W];
    assign x     = w0 ^ w2 ^ w8 ^ w13;
    assign w_new = {x[W_W-2:0], x[W_W-1]};
    assign m     = w0;

    // Bytes enter at the bottom, so after 64 of them the first byte is the top byte of word 0.
    always_ff @(posedge clk)
    begin
        if (ctl.shift_byte)
        begin
            q_reg <= {q_reg[VEC_W-sha1_pkg::BYTE_W-1:0], ctl.byte_val};
        end
        else if (ctl.step)
        begin
            q_reg <= {q_reg[VEC_W-W_W-1:0], w_new};
        end
    end

endmodule

/* rtl/sha1_round.sv */
// SHA-1 round unit: working words a..e, one round per cycle, and the chaining words.
// Depends on sha1_pkg for round functions, constants and the control struct.
module sha1_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha1_pkg::round_ctl_t ctl,
    input  sha1_pkg::word_t      m,
    output sha1_pkg::word_t      h [0:sha1_pkg::NUM_H-1]
);

    sha1_pkg::word_t h_reg [0:sha1_pkg::NUM_H-1];
    sha1_pkg::word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1_pkg::word_t t;

    assign t = {a_reg[26:0], a_reg[31:27]}
             + sha1_pkg::round_f(ctl.rnd, b_reg, c_reg, d_reg)
             + e_reg + sha1_pkg::round_k(ctl.rnd) + m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sha1_pkg::NUM_H; i++)
            begin
                h_reg[i] <= sha1_pkg::H_INIT[i];
            end
        end
        else if (ctl.load_iv)
        begin
            for (int i = 0; i < sha1_pkg::NUM_H; i++)
            begin
                h_reg[i] <= sha1_pkg::H_INIT[i];
            end
        end
        else if (ctl.add)
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (ctl.step)
        begin
            a_reg <= t;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assign h = h_reg;

endmodule

/* rtl/sha1_message_digest_top.sv */
// Top level of the SHA-1 digest block: stream ports, sequencer, length counting.
// Depends on sha1_pkg, sha1_sched and sha1_round.
//
//  channel   dir  handshake             contents
//  s_axis    in   tvalid/tready         tdata byte, tuser byte valid, tlast end of message
//  m_axis    out  tvalid/tready         tdata digest word and index, tlast fifth word
//
// A message byte is taken on each handshake while idle. The 64th byte of a block starts a compression
// that holds the input off through 80 rounds of the shared round unit and then a fold of
// the result into the chaining words. End of message shifts in padding
// and length one byte per cycle (64 minus the pending bytes, plus 64 more when the
// marker leaves no room for the length) with one or two compressions, then
// five digest words, each held until taken. Reset loads the initial chaining words.
module sha1_message_digest_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_axis_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam int PW = sha1_pkg::PEND_W;
    localparam int BW = sha1_pkg::BLK_W;
    localparam int LW = sha1_pkg::LEN_W;
    localparam int IW = sha1_pkg::IDX_W;
    localparam logic [PW-1:0] PEND_LAST = PW'((1 << PW) - 1);
    localparam logic [PW-1:0] PEND_LEN  = PW'(sha1_pkg::LEN_START);
    localparam sha1_pkg::rnd_t RND_LAST = sha1_pkg::RND_W'(sha1_pkg::ROUNDS - 1);
    localparam logic [IW-1:0] IDX_LAST  = IW'(sha1_pkg::NUM_H - 1);

    logic [2:0]     state_reg, state_next;
    logic [PW-1:0]  pend_reg, pend_next;
    logic [BW-1:0]  blk_reg, blk_next;
    logic [LW-1:0]  len_reg, len_next;
    logic           fin_reg, fin_next;
    logic           mark_reg, mark_next;
    logic           lenph_reg, lenph_next;
    sha1_pkg::rnd_t rnd_reg, rnd_next;
    logic [IW-1:0]  idx_reg, idx_next;

    sha1_pkg::sched_ctl_t sctl;
    sha1_pkg::round_ctl_t rctl;
    sha1_pkg::word_t      m_word;
    sha1_pkg::word_t      h_words [0:sha1_pkg::NUM_H-1];
    sha1_pkg::word_t      word_sel;
    logic                 in_acc, out_acc;

    sha1_sched u_sched (
        .clk (clk),
        .ctl (sctl),
        .m   (m_word)
    );

    sha1_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rctl),
        .m     (m_word),
        .h     (h_words)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        case (idx_reg)
            3'd0:    word_sel = h_words[0];
            3'd1:    word_sel = h_words[1];
            3'd2:    word_sel = h_words[2];
            3'd3:    word_sel = h_words[3];
            default: word_sel = h_words[4];
        endcase
    end

    assign m_axis_tdata = {5'b0, idx_reg, word_sel};
    assign m_axis_tlast = (idx_reg == IDX_LAST);

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        blk_next   = blk_reg;
        len_next   = len_reg;
        fin_next   = fin_reg;
        mark_next  = mark_reg;
        lenph_next = lenph_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        sctl       = '0;
        rctl       = '0;
        rctl.rnd   = rnd_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser)
                    begin
                        sctl.shift_byte = 1'b1;
                        sctl.byte_val   = s_axis_tdata;
                        pend_next       = PW'(pend_reg + 1'b1);
                    end
                    if (s_axis_tuser && (pend_reg == PEND_LAST))
                    begin
                        state_next = ST_ROUND;
                        rctl.init  = 1'b1;
                        rnd_next   = '0;
                        blk_next   = BW'(blk_reg + 1'b1);
                        fin_next   = s_axis_tlast;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                        fin_next   = 1'b1;
                    end
                end
            end

            ST_PAD:
            begin
                sctl.shift_byte = 1'b1;
                pend_next       = PW'(pend_reg + 1'b1);
                if (!mark_reg)
                begin
                    // The marker byte goes first; the length is fixed at this point.
                    sctl.byte_val = sha1_pkg::PAD_MARK;
                    mark_next     = 1'b1;
                    len_next      = {blk_reg, pend_reg, 3'b000};
                end
                else if (lenph_reg || (pend_reg == PEND_LEN))
                begin
                    sctl.byte_val = len_reg[LW-1 -: sha1_pkg::BYTE_W];
                    len_next      = {len_reg[LW-sha1_pkg::BYTE_W-1:0], 8'h00};
                    lenph_next    = 1'b1;
                end
                else
                begin
                    sctl.byte_val = '0;
                end
                if (pend_reg == PEND_LAST)
                begin
                    state_next = ST_ROUND;
                    rctl.init  = 1'b1;
                    rnd_next   = '0;
                    blk_next   = BW'(blk_reg + 1'b1);
                end
            end

            ST_ROUND:
            begin
                rctl.step = 1'b1;
                sctl.step = 1'b1;
                rnd_next  = sha1_pkg::RND_W'(rnd_reg + 1'b1);
                if (rnd_reg == RND_LAST)
                begin
                    state_next = ST_ADD;
                    rnd_next   = '0;
                end
            end

            ST_ADD:
            begin
                rctl.add = 1'b1;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (lenph_reg)
                begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end

            ST_OUT:
            begin
                if (out_acc)
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        rctl.load_iv = 1'b1;
                        state_next   = ST_IDLE;
                        pend_next    = '0;
                        blk_next     = '0;
                        fin_next     = 1'b0;
                        mark_next    = 1'b0;
                        lenph_next   = 1'b0;
                        idx_next     = '0;
                    end
                    else
                    begin
                        idx_next = IW'(idx_reg + 1'b1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            blk_reg   <= '0;
            fin_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            lenph_reg <= 1'b0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            blk_reg   <= blk_next;
            fin_reg   <= fin_next;
            mark_reg  <= mark_next;
            lenph_reg <= lenph_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    // The input side and the digest output are never open in the same cycle.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a digest word is offered");

    // The round counter never runs past the last round.
    a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg <= RND_LAST)
        else $error("round counter out of range");

    // Taking the fifth word returns the block to a fresh message.
    a_fresh_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && m_axis_tlast) |=> (s_axis_tready && (pend_reg == '0) && !fin_reg))
        else $error("block not reset after the final digest word");

    // A digest is only offered once the length bytes have gone in.
    a_out_after_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (lenph_reg && fin_reg))
        else $error("digest offered before the length was appended");

endmodule
